/* sv/pbd_pkg.sv */
`timescale 1ns / 1ps

package pbd_pkg;

  // Fixed field widths.
  localparam int PIX_W    = 8;
  localparam int IDX_W    = 17;
  localparam int SUM_W    = 25;
  localparam int CNT_W    = 18;
  localparam int LOW_W    = 7;
  localparam int IDX_SPAN = 1 << IDX_W;

  localparam int DEFAULT_MAX_PIXELS = 131072;
  localparam int QUEUE_DEPTH        = 4;

  localparam logic [PIX_W-1:0] THRESHOLD_RESET = 8'd60;
  localparam logic [PIX_W-1:0] LUM_START       = 8'd100;
  localparam logic [PIX_W-1:0] SNAP_LIMIT      = 8'd3;
  localparam logic [SUM_W-1:0] SUM_MAX         = {SUM_W{1'b1}};
  localparam logic [CNT_W-1:0] COUNT_MAX       = {CNT_W{1'b1}};

  // One pixel as it travels from the front end to the back end.
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [IDX_W-1:0] idx;
    logic             frame_end;
    logic             first;
  } pbd_item_t;

  // Number of compare-and-subtract steps needed to fold a pixel index into
  // a store whose depth is not a power of two; zero when a mask suffices.
  function automatic int red_steps(input int max_px);
    int k;
    k = 0;
    if (max_px >= IDX_SPAN || (max_px & (max_px - 1)) == 0) begin
      return 0;
    end
    while ((max_px << (k + 1)) < IDX_SPAN) begin
      k++;
    end
    return k + 1;
  endfunction

endpackage

/* sv/pbd_if.sv */
`timescale 1ns / 1ps

interface pbd_in_if;
  import pbd_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  logic [IDX_W-1:0] pixel_index;
  logic             frame_end;

  modport source (output valid, pixel, pixel_index, frame_end, input ready);
  modport sink (input valid, pixel, pixel_index, frame_end, output ready);
endinterface

interface pbd_out_if;
  import pbd_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] diff;
  logic             pending;
  logic             frame_done;
  logic             first_frame;
  logic [PIX_W-1:0] lum_avg;
  logic [LOW_W-1:0] lum_low;
  logic [PIX_W-1:0] lum_high;
  logic [PIX_W-1:0] lum_range;
  logic [PIX_W-1:0] lum_floor;
  logic [SUM_W-1:0] diff_sum;

  modport source (output valid, diff, pending, frame_done, first_frame, lum_avg, lum_low,
                  lum_high, lum_range, lum_floor, diff_sum, input ready);
  modport sink (input valid, diff, pending, frame_done, first_frame, lum_avg, lum_low,
                lum_high, lum_range, lum_floor, diff_sum, output ready);
endinterface

/* sv/pbd_div.sv */
`timescale 1ns / 1ps

module pbd_div import pbd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SUM_W-1:0] dividend_i,
  input  logic [CNT_W-1:0] divisor_i,
  output logic             done_o,
  output logic [SUM_W-1:0] quotient_o
);

  localparam int StepW = $clog2(SUM_W);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [StepW-1:0] step_q, step_d;
  logic [CNT_W-1:0] rem_q, rem_d;
  logic [CNT_W-1:0] dvs_q, dvs_d;
  logic [SUM_W-1:0] quo_q, quo_d;
  logic [CNT_W:0]   rem_sh;
  logic             ge;

  // Restoring division, one quotient bit per cycle.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    rem_sh = {rem_q, quo_q[SUM_W-1]};
    ge     = rem_sh >= {1'b0, dvs_q};
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = '0;
      dvs_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = ge ? CNT_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[CNT_W-1:0];
      quo_d = {quo_q[SUM_W-2:0], ge};
      step_d = step_q + 1'b1;
      if (step_q == StepW'(SUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

/* sv/pbd_front.sv */
`timescale 1ns / 1ps

module pbd_front import pbd_pkg::*; #(
  parameter int MAX_PIXELS = DEFAULT_MAX_PIXELS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pbd_in_if.sink    pix_i,
  input  logic      full_i,
  output logic      push_o,
  output pbd_item_t push_item_o
);

  localparam int RedSteps = red_steps(MAX_PIXELS);
  localparam int CntW     = (RedSteps > 1) ? $clog2(RedSteps) : 1;
  localparam logic [IDX_W-1:0] FastMask =
    (MAX_PIXELS >= IDX_SPAN) ? {IDX_W{1'b1}} : IDX_W'(MAX_PIXELS - 1);

  logic            first_q, first_d;
  logic            busy_q, busy_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  pbd_item_t       work_q, work_d;
  pbd_item_t       stepped;
  logic [IDX_W-1:0] sub;
  logic            accept;

  assign pix_i.ready = !busy_q && !full_i;
  assign accept      = pix_i.valid && pix_i.ready;

  always_comb begin
    first_d     = first_q;
    busy_d      = busy_q;
    cnt_d       = cnt_q;
    work_d      = work_q;
    push_o      = 1'b0;
    push_item_o = work_q;
    // One fold step per cycle, largest multiple of the store depth first.
    sub     = IDX_W'(MAX_PIXELS) << cnt_q;
    stepped = work_q;
    if (work_q.idx >= sub) begin
      stepped.idx = work_q.idx - sub;
    end

    if (accept) begin
      if (pix_i.frame_end) begin
        first_d = 1'b0;
      end
      work_d.pixel     = pix_i.pixel;
      work_d.idx       = pix_i.pixel_index;
      work_d.frame_end = pix_i.frame_end;
      work_d.first     = first_q;
      if (RedSteps == 0) begin
        push_o               = 1'b1;
        push_item_o          = work_d;
        push_item_o.idx      = pix_i.pixel_index & FastMask;
      end else begin
        busy_d = 1'b1;
        cnt_d  = CntW'(RedSteps - 1);
      end
    end else if (busy_q) begin
      work_d = stepped;
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d      = 1'b0;
        push_o      = 1'b1;
        push_item_o = stepped;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b1;
      busy_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      first_q <= first_d;
      busy_q  <= busy_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
  end

endmodule

/* sv/pbd_queue.sv */
`timescale 1ns / 1ps

module pbd_queue import pbd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  pbd_item_t push_item_i,
  output logic      full_o,
  input  logic      pop_i,
  output pbd_item_t head_o,
  output logic      empty_o
);

  localparam int PtrW = $clog2(QUEUE_DEPTH);

  pbd_item_t     slots_q [QUEUE_DEPTH];
  logic [PtrW:0] wr_q, rd_q;

  assign empty_o = wr_q == rd_q;
  assign full_o  = (wr_q[PtrW-1:0] == rd_q[PtrW-1:0]) && (wr_q[PtrW] != rd_q[PtrW]);
  assign head_o  = slots_q[rd_q[PtrW-1:0]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_q[PtrW-1:0]] <= push_item_i;
    end
  end

endmodule

/* sv/pbd_back.sv */
`timescale 1ns / 1ps

module pbd_back import pbd_pkg::*; #(
  parameter int MAX_PIXELS = DEFAULT_MAX_PIXELS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [PIX_W-1:0] threshold_i,
  input  pbd_item_t        head_i,
  input  logic             empty_i,
  output logic             pop_o,
  pbd_out_if.source        res_o
);

  localparam int AddrW = $clog2(MAX_PIXELS);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_DIV  = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [PIX_W-1:0] bg_mem [MAX_PIXELS];
  logic [PIX_W-1:0] bg_q;
  pbd_item_t        item_q;

  logic [SUM_W-1:0] lum_sum_q, lum_sum_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [LOW_W-1:0] low_q, low_d;
  logic [PIX_W-1:0] high_q, high_d;
  logic [SUM_W-1:0] dtot_q, dtot_d;

  logic             out_valid_q, out_valid_d;
  logic             load_item, load_stats;

  logic signed [PIX_W:0] delta;
  logic signed [PIX_W:0] step;
  logic [PIX_W-1:0] adiff, bg_new;
  logic             pend;
  logic [SUM_W:0]   lum_add, dtot_add;
  logic             div_start, div_done;
  logic [SUM_W-1:0] quotient;
  logic [PIX_W-1:0] avg;
  logic [PIX_W-1:0] range;
  logic signed [PIX_W+2:0] floor_raw;
  logic [PIX_W-1:0] floor_val;

  // The back end takes an item only when idle and the result register is free or being taken.
  assign pop_o = (state_q == ST_IDLE) && !empty_i && (!out_valid_q || res_o.ready);

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      bg_q   <= bg_mem[AddrW'(head_i.idx)];
      item_q <= head_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_EXEC) begin
      bg_mem[AddrW'(item_q.idx)] <= bg_new;
    end
  end

  // Per-pixel difference and background update.
  always_comb begin
    delta = $signed({1'b0, item_q.pixel}) - $signed({1'b0, bg_q});
    adiff = delta[PIX_W] ? PIX_W'(-delta) : delta[PIX_W-1:0];
    step  = delta >>> 2;
    if (item_q.first) begin
      adiff  = '0;
      bg_new = item_q.pixel;
    end else if (adiff < SNAP_LIMIT) begin
      bg_new = item_q.pixel;
    end else begin
      bg_new = bg_q + step[PIX_W-1:0];
    end
    pend = adiff > threshold_i;
  end

  // Frame statistics, saturating.
  always_comb begin
    lum_add  = {1'b0, lum_sum_q} + (SUM_W + 1)'(item_q.pixel);
    dtot_add = {1'b0, dtot_q} + (SUM_W + 1)'(adiff);
    lum_sum_d = lum_add[SUM_W] ? SUM_MAX : lum_add[SUM_W-1:0];
    dtot_d    = dtot_add[SUM_W] ? SUM_MAX : dtot_add[SUM_W-1:0];
    count_d   = (count_q == COUNT_MAX) ? COUNT_MAX : count_q + 1'b1;
    low_d     = (item_q.pixel < {1'b0, low_q}) ? item_q.pixel[LOW_W-1:0] : low_q;
    high_d    = (item_q.pixel > high_q) ? item_q.pixel : high_q;
  end

  assign div_start = (state_q == ST_EXEC) && item_q.frame_end;

  pbd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (lum_sum_d),
    .divisor_i  (count_d),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_comb begin
    avg       = (|quotient[SUM_W-1:PIX_W]) ? {PIX_W{1'b1}} : quotient[PIX_W-1:0];
    range     = res_o.lum_high - {1'b0, res_o.lum_low};
    floor_raw = $signed({3'b000, range}) - $signed({4'b0000, res_o.lum_low})
              - $signed({3'b000, avg});
    if (!res_o.first_frame) begin
      floor_val = '0;
    end else if (floor_raw < 11'sd1) begin
      floor_val = 8'd1;
    end else begin
      floor_val = floor_raw[PIX_W-1:0];
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    load_item   = 1'b0;
    load_stats  = 1'b0;
    if (out_valid_q && res_o.ready) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (pop_o) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        load_item = 1'b1;
        if (item_q.frame_end) begin
          state_d = ST_DIV;
        end else begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          load_stats  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      lum_sum_q   <= '0;
      count_q     <= '0;
      low_q       <= LUM_START[LOW_W-1:0];
      high_q      <= LUM_START;
      dtot_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (state_q == ST_EXEC) begin
        if (item_q.frame_end) begin
          lum_sum_q <= '0;
          count_q   <= '0;
          low_q     <= LUM_START[LOW_W-1:0];
          high_q    <= LUM_START;
          dtot_q    <= '0;
        end else begin
          lum_sum_q <= lum_sum_d;
          count_q   <= count_d;
          low_q     <= low_d;
          high_q    <= high_d;
          dtot_q    <= dtot_d;
        end
      end
    end
  end

  // Result register. Statistics captured at the frame end are held here
  // while the average is being divided out.
  always_ff @(posedge clk_i) begin
    if (load_item) begin
      res_o.diff        <= adiff;
      res_o.pending     <= pend && !item_q.first;
      res_o.first_frame <= item_q.first;
      res_o.frame_done  <= 1'b0;
      res_o.lum_avg     <= '0;
      res_o.lum_range   <= '0;
      res_o.lum_floor   <= '0;
      if (item_q.frame_end) begin
        res_o.lum_low  <= low_d;
        res_o.lum_high <= high_d;
        res_o.diff_sum <= dtot_d;
      end else begin
        res_o.lum_low  <= '0;
        res_o.lum_high <= '0;
        res_o.diff_sum <= '0;
      end
    end
    if (load_stats) begin
      res_o.frame_done <= 1'b1;
      res_o.lum_avg    <= avg;
      res_o.lum_range  <= range;
      res_o.lum_floor  <= floor_val;
    end
  end

  assign res_o.valid = out_valid_q;

endmodule

/* sv/pixel_background_diff_engine.sv */
`timescale 1ns / 1ps

// Running-average background subtraction for a luminance stream. Each pixel
// item carries its luminance and an index into a background store of
// MAX_PIXELS entries (indexes are folded modulo MAX_PIXELS). The first frame
// after reset only loads the store; its result items show first_frame high
// and zero difference. After that each result gives |pixel - background| and
// a pending flag when that difference is above diff_threshold, while the
// stored value snaps to the pixel for differences below 3 and otherwise moves
// a quarter of the way toward it. The result of a frame's last pixel also
// carries the frame statistics. A front end takes pixels into a four-deep
// queue; when MAX_PIXELS is not a power of two it folds each index by
// compare-and-subtract steps and takes no new pixel meanwhile. The back
// end reads the store with a registered port and writes it back in the
// next cycle. A frame-end pixel adds a serial division for the average,
// during which the back end takes no new pixel. One result register sits
// at the output; the back end proceeds as soon as that register is free or
// being taken. The background store has no reset: every index must be
// written during the first frame before later frames read it. Write
// diff_threshold only while the block is idle.

module pixel_background_diff_engine import pbd_pkg::*; #(
  parameter int MAX_PIXELS = DEFAULT_MAX_PIXELS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [PIX_W-1:0] cfg_wdata_i,
  pbd_in_if.sink           pix_i,
  pbd_out_if.source        res_o
);

  logic [PIX_W-1:0] threshold_q;
  logic             push;
  pbd_item_t        push_item;
  logic             full;
  logic             pop;
  pbd_item_t        head;
  logic             empty;

  // The single configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= THRESHOLD_RESET;
    end else if (cfg_we_i) begin
      threshold_q <= cfg_wdata_i;
    end
  end

  // Front end: accepts pixels, folds the index and tags the loading frame.
  pbd_front #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_i       (pix_i),
    .full_i      (full),
    .push_o      (push),
    .push_item_o (push_item)
  );

  // Queue that lets the front and back ends stall independently.
  pbd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (full),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (empty)
  );

  // Back end: background store, frame statistics and the result register.
  pbd_back #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .threshold_i (threshold_q),
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .res_o       (res_o)
  );

endmodule

/* sv/pbd_checker.sv */
`timescale 1ns / 1ps

module pbd_checker import pbd_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             valid,
  input logic             ready,
  input logic [PIX_W-1:0] diff,
  input logic             pending,
  input logic             frame_done,
  input logic             first_frame,
  input logic [PIX_W-1:0] lum_avg,
  input logic [LOW_W-1:0] lum_low,
  input logic [PIX_W-1:0] lum_high,
  input logic [PIX_W-1:0] lum_range,
  input logic [PIX_W-1:0] lum_floor,
  input logic [SUM_W-1:0] diff_sum
);

  // A stalled result keeps its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid && !ready |=> valid && $stable(diff) && $stable(frame_done)
      && $stable(lum_avg) && $stable(diff_sum))
    else $error("result changed while stalled");

  // Ordinary pixels carry no statistics.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid && !frame_done |-> lum_avg == '0 && lum_low == '0 && lum_high == '0
      && lum_range == '0 && lum_floor == '0 && diff_sum == '0)
    else $error("statistics on a pixel that does not end a frame");

  // The loading frame reports no differences.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid && first_frame |-> diff == '0 && !pending && diff_sum == '0)
    else $error("difference reported during the loading frame");

  // The range is consistent with the reported extremes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid && frame_done |-> lum_range == PIX_W'(lum_high - {1'b0, lum_low}))
    else $error("luminance range inconsistent");

  // The floor is clamped on the loading frame and zero afterwards.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid && frame_done |-> (first_frame && lum_floor != '0)
      || (!first_frame && lum_floor == '0))
    else $error("luminance floor wrong");

endmodule

bind pixel_background_diff_engine pbd_checker u_pbd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .valid       (res_o.valid),
  .ready       (res_o.ready),
  .diff        (res_o.diff),
  .pending     (res_o.pending),
  .frame_done  (res_o.frame_done),
  .first_frame (res_o.first_frame),
  .lum_avg     (res_o.lum_avg),
  .lum_low     (res_o.lum_low),
  .lum_high    (res_o.lum_high),
  .lum_range   (res_o.lum_range),
  .lum_floor   (res_o.lum_floor),
  .diff_sum    (res_o.diff_sum)
);
